// File: rtl/lbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared constants and types for the 3x3 local binary pattern stream block.
// ----------------------------------------------------------------------------
package lbp_pkg;

  localparam int MAX_WIDTH_DEFAULT  = 2048;
  localparam int PIXEL_BITS_DEFAULT = 8;

  localparam int PIXEL_IN_BITS  = 8;
  localparam int CODE_BITS      = 8;
  localparam int LINE_REG_BITS  = 12;
  localparam int HEIGHT_BITS    = 13;
  localparam int ROW_BITS       = 12;
  localparam int MAX_HEIGHT     = 4096;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 13;

  localparam logic [LINE_REG_BITS-1:0] LINE_WIDTH_RESET   = 12'd640;
  localparam logic [HEIGHT_BITS-1:0]   FRAME_HEIGHT_RESET = 13'd480;

  localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_WIDTH   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

  typedef struct packed {
    logic valid;
    logic emit;
    logic last;
  } step_t;

endpackage

// File: rtl/lbp_line_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbp_line_mem
// Simple dual-port line memory with one write port and a registered read port.
// ----------------------------------------------------------------------------
module lbp_line_mem #(
  parameter int DEPTH     = lbp_pkg::MAX_WIDTH_DEFAULT,
  parameter int DATA_BITS = 2 * lbp_pkg::PIXEL_BITS_DEFAULT,
  parameter int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [DATA_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [DATA_BITS-1:0] rd_data
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/lbp_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbp_window
// Six window registers and the eight neighbor compares that form the code.
// ----------------------------------------------------------------------------
module lbp_window #(
  parameter int PIXEL_BITS = lbp_pkg::PIXEL_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           shift,
  input  logic [PIXEL_BITS-1:0]          top,
  input  logic [PIXEL_BITS-1:0]          mid,
  input  logic [PIXEL_BITS-1:0]          bot,
  output logic [lbp_pkg::CODE_BITS-1:0]  code
);

  // Entries 0 and 1 hold the top row, 2 and 3 the middle row, 4 and 5 the
  // bottom row, older column first. Entry 3 is the center pixel.
  logic [PIXEL_BITS-1:0] win [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (shift) begin
      win[0] <= win[1];
      win[1] <= top;
      win[2] <= win[3];
      win[3] <= mid;
      win[4] <= win[5];
      win[5] <= bot;
    end
  end

  always_comb begin
    code[7] = (win[0] >= win[3]);
    code[6] = (win[1] >= win[3]);
    code[5] = (top    >= win[3]);
    code[4] = (mid    >= win[3]);
    code[3] = (bot    >= win[3]);
    code[2] = (win[5] >= win[3]);
    code[1] = (win[4] >= win[3]);
    code[0] = (win[2] >= win[3]);
  end

endmodule

// File: rtl/lbp_3x3_raster_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbp_3x3_raster_stream
// 3x3 local binary pattern over a raster pixel stream with a single line memory holding two rows.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock as long as codes are taken when they
// are offered. Each pixel reads both previous rows from a single line memory
// in the cycle it is accepted and writes them back, shifted by one row, when
// it leaves the window stage, so one read port and one write port of that
// memory set the cost of one cycle per pixel. A held code blocks the window
// stage, and with it the input, until the code is taken, when that stage
// holds a pixel that gives a code. A code is registered at the output when
// the pixel below and to the right of its center leaves the window stage.
// Border pixels give no code, and the final code of each frame carries
// last_code. Line memory contents are not cleared after reset, and no
// clearing pass is needed, since the first two rows of a frame fill it
// before any code depends on it. Register writes restart the frame and
// belong in idle periods.
// ----------------------------------------------------------------------------
module lbp_3x3_raster_stream #(
  parameter int MAX_WIDTH  = lbp_pkg::MAX_WIDTH_DEFAULT,
  parameter int PIXEL_BITS = lbp_pkg::PIXEL_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [lbp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [lbp_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [lbp_pkg::PIXEL_IN_BITS-1:0]   pixel,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lbp_pkg::CODE_BITS-1:0]       lbp_code,
  output logic                                last_code
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = CW + 1;
  localparam int LWW = (WW > lbp_pkg::LINE_REG_BITS) ? WW : lbp_pkg::LINE_REG_BITS;
  localparam int RB  = lbp_pkg::ROW_BITS;
  localparam int HB  = lbp_pkg::HEIGHT_BITS;

  logic [lbp_pkg::LINE_REG_BITS-1:0] line_width;
  logic [HB-1:0]                     frame_height;
  logic [CW-1:0]                     col_cnt;
  logic [RB-1:0]                     row_cnt;

  logic [LWW-1:0] lw_ext;
  logic [LWW-1:0] eff_width;
  logic [WW-1:0]  last_col;
  logic [HB-1:0]  eff_height;
  logic [RB-1:0]  last_row;
  logic           at_last_col;
  logic           at_last_row;

  logic [PIXEL_BITS-1:0] pix_in;
  logic                  accept;

  lbp_pkg::step_t        s1;
  logic [CW-1:0]         s1_col;
  logic [PIXEL_BITS-1:0] s1_pix;
  logic                  s1_advance;

  logic [2*PIXEL_BITS-1:0]       rd_data;
  logic [lbp_pkg::CODE_BITS-1:0] code;

  always_comb begin
    lw_ext = LWW'(line_width);
    if (lw_ext < LWW'(3)) begin
      eff_width = LWW'(3);
    end else if (lw_ext > LWW'(MAX_WIDTH)) begin
      eff_width = LWW'(MAX_WIDTH);
    end else begin
      eff_width = lw_ext;
    end
    last_col = WW'(eff_width - LWW'(1));

    if (frame_height < HB'(3)) begin
      eff_height = HB'(3);
    end else if (frame_height > HB'(lbp_pkg::MAX_HEIGHT)) begin
      eff_height = HB'(lbp_pkg::MAX_HEIGHT);
    end else begin
      eff_height = frame_height;
    end
    last_row = RB'(eff_height - HB'(1));
  end

  assign at_last_col = ({1'b0, col_cnt} == last_col);
  assign at_last_row = (row_cnt == last_row);

  assign pix_in     = PIXEL_BITS'({{16{1'b0}}, pixel});
  assign s1_advance = s1.valid && (!s1.emit || !out_valid || out_ready);
  assign in_ready   = !s1.valid || s1_advance;
  assign accept     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= lbp_pkg::LINE_WIDTH_RESET;
      frame_height <= lbp_pkg::FRAME_HEIGHT_RESET;
      col_cnt      <= '0;
      row_cnt      <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lbp_pkg::REG_LINE_WIDTH: begin
          line_width <= cfg_data[lbp_pkg::LINE_REG_BITS-1:0];
          col_cnt    <= '0;
          row_cnt    <= '0;
        end
        lbp_pkg::REG_FRAME_HEIGHT: begin
          frame_height <= cfg_data[HB-1:0];
          col_cnt      <= '0;
          row_cnt      <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (at_last_col) begin
        col_cnt <= '0;
        row_cnt <= at_last_row ? '0 : row_cnt + RB'(1);
      end else begin
        col_cnt <= col_cnt + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else if (accept) begin
      s1.valid <= 1'b1;
      s1.emit  <= (row_cnt >= RB'(2)) && (col_cnt >= CW'(2));
      s1.last  <= at_last_row && at_last_col;
    end else if (s1_advance) begin
      s1.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col <= col_cnt;
      s1_pix <= pix_in;
    end
  end

  // Each entry packs the row before last in the upper half and the previous
  // row in the lower half.
  lbp_line_mem #(
    .DEPTH     (MAX_WIDTH),
    .DATA_BITS (2 * PIXEL_BITS),
    .ADDR_BITS (CW)
  ) u_line_mem (
    .clk     (clk),
    .wr_en   (s1_advance),
    .wr_addr (s1_col),
    .wr_data ({rd_data[PIXEL_BITS-1:0], s1_pix}),
    .rd_en   (accept),
    .rd_addr (col_cnt),
    .rd_data (rd_data)
  );

  lbp_window #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk   (clk),
    .rst   (rst),
    .shift (s1_advance),
    .top   (rd_data[2*PIXEL_BITS-1:PIXEL_BITS]),
    .mid   (rd_data[PIXEL_BITS-1:0]),
    .bot   (s1_pix),
    .code  (code)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1.emit) begin
      lbp_code  <= code;
      last_code <= s1.last;
    end
  end

  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && s1.emit) |=> out_valid)
    else $error("code leaving the window stage did not reach the output");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, col_cnt} <= last_col))
    else $error("column counter ran past the line width");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1.valid)
    else $error("accepted transfer did not enter the window stage");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (s1.valid && s1.emit && out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while the window stage is blocked");

endmodule
